@@ src/fsme_pkg.sv @@
// ----------------------------------------------------------------------------
// fsme_pkg
// shared constants and types of the flow shop makespan evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package fsme_pkg;

  localparam int MAX_MACHINES = 32;
  localparam int MAX_JOBS     = 256;
  localparam int TIME_BITS    = 16;

  localparam int MACH_BITS    = $clog2(MAX_MACHINES);
  localparam int JOB_BITS     = $clog2(MAX_JOBS);
  localparam int TABLE_DEPTH  = MAX_MACHINES * MAX_JOBS;
  localparam int CNT_BITS     = $clog2(MAX_MACHINES + 1);
  localparam int CFG_BITS     = 6;

  localparam int SPAN_BITS    = 25;
  localparam logic [SPAN_BITS-1:0] SPAN_MAX = {SPAN_BITS{1'b1}};

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_SCHEDULE = 1'b1;

  typedef struct packed {
    logic                 is_sched;
    logic [MACH_BITS-1:0] machine;
    logic [JOB_BITS-1:0]  job;
    logic [TIME_BITS-1:0] ptime;
    logic                 last;
  } item_t;

endpackage

`default_nettype wire

@@ src/flow_shop_makespan_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// flow_shop_makespan_evaluator_unit
// permutation flow shop makespan evaluator
//
// input channel (in_valid/in_ready): mode 0 items write proc_time into the
// table at (machine, job); mode 1 items schedule job as the next one of the
// current sequence, and the item with last set closes the sequence.
// output channel (out_valid/out_ready): one makespan per closed sequence.
// config channel (cfg_valid/cfg_ready): machines_in_use, always ready;
// write it only while the block is idle.
// a two-item queue sits behind the input, so items are taken while the
// back end works. a write item is done as the back end pops it; a schedule
// item walks the machines in use, one machine per cycle through the table's
// single read port; a closing item then passes through S_EMIT, where
// makespan is registered and out_valid set.
// reset clears the queue, the completion row and the output, and sets
// machines_in_use to 1; the table holds garbage until written.
// a stalled receiver holds the result; the back end waits at the next
// closing item and the queue then fills and drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_shop_makespan_evaluator_unit import fsme_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 mode,
  input  wire logic [MACH_BITS-1:0] machine,
  input  wire logic [JOB_BITS-1:0]  job,
  input  wire logic [TIME_BITS-1:0] proc_time,
  input  wire logic                 last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SPAN_BITS-1:0]      makespan,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_BITS-1:0]  cfg_data
);

  logic [CFG_BITS-1:0] machines_in_use;
  logic                q_valid;
  item_t               q_item;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      machines_in_use <= CFG_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      machines_in_use <= cfg_data;
    end
  end

  fsme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .machine   (machine),
    .job       (job),
    .proc_time (proc_time),
    .last      (last),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fsme_back u_back (
    .clk             (clk),
    .rst             (rst),
    .machines_in_use (machines_in_use),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .makespan        (makespan)
  );

endmodule

`default_nettype wire

@@ src/fsme_front.sv @@
// ----------------------------------------------------------------------------
// fsme_front
// takes input items, classifies them as table writes or schedule steps
// and holds them in a short queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module fsme_front import fsme_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 mode,
  input  wire logic [MACH_BITS-1:0] machine,
  input  wire logic [JOB_BITS-1:0]  job,
  input  wire logic [TIME_BITS-1:0] proc_time,
  input  wire logic                 last,
  output logic                      q_valid,
  output item_t                     q_item,
  input  wire logic                 q_pop
);

  item_t                q_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] q_count;
  logic                 push;
  logic                 pop;
  item_t                new_item;

  assign in_ready = (q_count != QCNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem[rd_ptr];

  always_comb begin
    new_item.is_sched = (mode == MODE_SCHEDULE);
    new_item.machine  = machine;
    new_item.job      = job;
    new_item.ptime    = proc_time;
    new_item.last     = last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + QCNT_BITS'(1);
        2'b01:   q_count <= q_count - QCNT_BITS'(1);
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/fsme_back.sv @@
// ----------------------------------------------------------------------------
// fsme_back
// executes queued items: table writes, and per-machine max-and-add walks
// over the completion row, one machine per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fsme_back import fsme_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [CFG_BITS-1:0]  machines_in_use,
  input  wire logic                 q_valid,
  input  wire item_t                q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SPAN_BITS-1:0]      makespan
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;

  logic [TIME_BITS-1:0] proc_mem [TABLE_DEPTH];
  logic [SPAN_BITS-1:0] row_mem  [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] row_valid;

  logic [JOB_BITS-1:0]  cur_job;
  logic                 cur_last;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  issue_cnt;
  logic                 rd_vld;
  logic [MACH_BITS-1:0] rd_m;
  logic [TIME_BITS-1:0] p_rd;
  logic [SPAN_BITS-1:0] row_rd;
  logic [SPAN_BITS-1:0] above;
  logic [SPAN_BITS-1:0] span;

  logic [CNT_BITS-1:0]  cnt_next;
  logic                 issue;
  logic [SPAN_BITS-1:0] prev;
  logic [SPAN_BITS-1:0] base;
  logic [SPAN_BITS-1:0] top;
  logic [SPAN_BITS:0]   sum;
  logic [SPAN_BITS-1:0] above_next;
  logic                 rd_final;
  logic                 do_write;

  // effective machine count
  always_comb begin
    if (machines_in_use == '0) begin
      cnt_next = CNT_BITS'(1);
    end else if ({{(32-CFG_BITS){1'b0}}, machines_in_use} > 32'(MAX_MACHINES)) begin
      cnt_next = CNT_BITS'(MAX_MACHINES);
    end else begin
      cnt_next = CNT_BITS'(machines_in_use);
    end
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign do_write = q_pop && !q_item.is_sched;
  assign issue    = (state == S_RUN) && (issue_cnt < cnt);

  assign prev       = row_valid[rd_m] ? row_rd : '0;
  assign base       = (rd_m == '0) ? '0 : above;
  assign top        = (prev > base) ? prev : base;
  assign sum        = {1'b0, top} + (SPAN_BITS+1)'(p_rd);
  assign above_next = (sum > {1'b0, SPAN_MAX}) ? SPAN_MAX : sum[SPAN_BITS-1:0];
  assign rd_final   = rd_vld && ({1'b0, rd_m} == cnt - CNT_BITS'(1));

  // processing-time table
  always_ff @(posedge clk) begin
    if (do_write) begin
      proc_mem[{q_item.machine, q_item.job}] <= q_item.ptime;
    end
    p_rd <= proc_mem[{issue_cnt[MACH_BITS-1:0], cur_job}];
  end

  // completion row
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      row_mem[rd_m] <= above_next;
    end
    row_rd <= row_mem[issue_cnt[MACH_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_sched) begin
      cur_job  <= q_item.job;
      cur_last <= q_item.last;
      cnt      <= cnt_next;
    end
    if (rd_vld) begin
      above <= above_next;
    end
    if (rd_final && cur_last) begin
      span <= above_next;
    end
    if (issue) begin
      rd_m <= issue_cnt[MACH_BITS-1:0];
    end
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      makespan <= span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_cnt <= '0;
      rd_vld    <= 1'b0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= issue;
      if (issue) begin
        issue_cnt <= issue_cnt + CNT_BITS'(1);
      end
      if (rd_final && cur_last) begin
        row_valid <= '0;
      end else if (rd_vld) begin
        row_valid[rd_m] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          issue_cnt <= '0;
          if (q_pop && q_item.is_sched) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (rd_final) begin
            if (cur_last) begin
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_read_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == S_RUN)
    else $error("table read outside a schedule walk");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> {1'b0, rd_m} < cnt)
    else $error("machine beyond count in use");

  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> row_valid == '0 && !rd_vld)
    else $error("completion row not cleared at sequence end");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    rd_final && !cur_last |=> state == S_IDLE && !rd_vld)
    else $error("walk continued past last machine");

endmodule

`default_nettype wire
